// ===== sv/path_mtu_probe_search_assert.svh =====
`ifndef PATH_MTU_PROBE_SEARCH_ASSERT_SVH
`define PATH_MTU_PROBE_SEARCH_ASSERT_SVH
// concurrent check that holds outside reset
`define PMPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`endif

// ===== sv/pmps_pkg.sv =====
package pmps_pkg;
	localparam int PENDING_DEPTH_DEF = 8;
	localparam int MTU_FLOOR_DEF = 576;
	localparam int MTU_CEIL_DEF = 9000;
	localparam logic [13:0] DEF_FLOOR = 14'd1200;
	localparam logic [13:0] DEF_CEIL = 14'd1500;
	localparam logic [13:0] DEF_STEP = 14'd10;
	localparam logic [7:0] DEF_LIMIT = 8'd3;

	localparam logic [2:0] F_ENABLE = 3'd0;
	localparam logic [2:0] F_DISABLE = 3'd1;
	localparam logic [2:0] F_RESP = 3'd2;
	localparam logic [2:0] F_INPROBE = 3'd3;
	localparam logic [2:0] F_SAMPLE = 3'd4;

	localparam logic [1:0] K_PROBE = 2'd0;
	localparam logic [1:0] K_CHANGE = 2'd1;
	localparam logic [1:0] K_REPLY = 2'd2;

	localparam logic [1:0] PH_UNKNOWN = 2'd0;
	localparam logic [1:0] PH_SEARCH = 2'd1;
	localparam logic [1:0] PH_VALID = 2'd2;
	localparam logic [1:0] PH_BLACK = 2'd3;

	localparam logic [1:0] REG_FLOOR = 2'd0;
	localparam logic [1:0] REG_CEIL = 2'd1;
	localparam logic [1:0] REG_STEP = 2'd2;
	localparam logic [1:0] REG_LIMIT = 2'd3;

	typedef struct packed {
		logic [2:0] func;
		logic [31:0] tag;
		logic ok;
		logic inbound;
		logic [15:0] probe_bytes;
		logic [13:0] loss_permyriad;
		logic [31:0] rtt_millis;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic on_inbound;
		logic [31:0] probe_tag;
		logic [15:0] size_bytes;
		logic [13:0] prior_mtu;
		logic from_probe;
		logic reply_ok;
		logic [1:0] path_phase;
		logic final_res;
	} res_t;

	typedef struct packed {
		logic [13:0] fl;
		logic [13:0] ce;
		logic [13:0] st;
		logic [7:0] limit;
	} cfg_t;
endpackage

// ===== sv/path_mtu_probe_search.sv =====
// channel   | dir | handshake          | payload
// s_axis    | in  | tvalid/tready      | tdata item, func in tuser
// m_axis    | out | tvalid/tready      | tdata result, kind in tuser, tlast final_res
// apb       | in  | psel/penable       | four config registers at 4*i
// an item is registered and decoded into up to two results; one word goes out per
// cycle while m_axis_tready is high; the next item waits until the slots are empty
// the result slots hold while m_axis_tready is low; the input register then holds
// reset restores path state, clears pending valid bits, sets tag counter to 1; no clearing pass
module path_mtu_probe_search import pmps_pkg::*; #(
	parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
	parameter int MTU_FLOOR = MTU_FLOOR_DEF,
	parameter int MTU_CEIL = MTU_CEIL_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// tag[31:0], ok, inbound, probe_bytes[15:0], loss_permyriad[13:0], rtt_millis[31:0]
	input logic [95:0] s_axis_tdata,
	// func[2:0]
	input logic [2:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// on_inbound, probe_tag[31:0], size_bytes[15:0], prior_mtu[13:0], from_probe,
	// reply_ok, path_phase[1:0], pad
	output logic [71:0] m_axis_tdata,
	// kind[1:0]
	output logic [1:0] m_axis_tuser,
	output logic m_axis_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	cfg_t cfg;
	item_t it;
	res_t r;

	assign pready = 1'b1;
	pmps_regs #(.MTU_FLOOR(MTU_FLOOR), .MTU_CEIL(MTU_CEIL)) u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	assign it.func = s_axis_tuser;
	assign it.tag = s_axis_tdata[31:0];
	assign it.ok = s_axis_tdata[32];
	assign it.inbound = s_axis_tdata[33];
	assign it.probe_bytes = s_axis_tdata[49:34];
	assign it.loss_permyriad = s_axis_tdata[63:50];
	assign it.rtt_millis = s_axis_tdata[95:64];

	pmps_core #(.PENDING_DEPTH(PENDING_DEPTH), .MTU_FLOOR(MTU_FLOOR),
			.MTU_CEIL(MTU_CEIL)) u_core (
		.clk, .arst_n, .cfg, .in_vld(s_axis_tvalid), .in_item(it),
		.in_rdy(s_axis_tready), .out_vld(m_axis_tvalid), .out_res(r),
		.out_rdy(m_axis_tready)
	);

	assign m_axis_tuser = r.kind;
	assign m_axis_tlast = r.final_res;
	assign m_axis_tdata = {5'd0, r.path_phase, r.reply_ok, r.from_probe, r.prior_mtu,
		r.size_bytes, r.probe_tag, r.on_inbound};
endmodule

// ===== sv/pmps_regs.sv =====
module pmps_regs import pmps_pkg::*; #(
	parameter int MTU_FLOOR = MTU_FLOOR_DEF,
	parameter int MTU_CEIL = MTU_CEIL_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t cfg
);
	localparam logic [13:0] FLR = 14'(MTU_FLOOR);
	localparam logic [13:0] CEL = 14'(MTU_CEIL);
	logic [13:0] floor_q, ceil_q, step_q;
	logic [7:0] limit_q;
	logic [13:0] f, c;
	logic [1:0] idx;
	assign idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= DEF_FLOOR;
			ceil_q <= DEF_CEIL;
			step_q <= DEF_STEP;
			limit_q <= DEF_LIMIT;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_FLOOR: floor_q <= pwdata[13:0];
				REG_CEIL: ceil_q <= pwdata[13:0];
				REG_STEP: step_q <= pwdata[13:0];
				REG_LIMIT: limit_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FLOOR: prdata = {18'd0, floor_q};
			REG_CEIL: prdata = {18'd0, ceil_q};
			REG_STEP: prdata = {18'd0, step_q};
			REG_LIMIT: prdata = {24'd0, limit_q};
			default: prdata = '0;
		endcase
	end

	assign f = (floor_q < FLR) ? FLR : floor_q;
	assign c = (ceil_q > CEL) ? CEL : ceil_q;
	assign cfg.fl = (f >= c) ? DEF_FLOOR : f;
	assign cfg.ce = (f >= c) ? DEF_CEIL : c;
	assign cfg.st = (step_q == 14'd0) ? DEF_STEP : step_q;
	assign cfg.limit = limit_q;
endmodule

// ===== sv/pmps_core.sv =====
module pmps_core import pmps_pkg::*; #(
	parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
	parameter int MTU_FLOOR = MTU_FLOOR_DEF,
	parameter int MTU_CEIL = MTU_CEIL_DEF
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_vld,
	input item_t in_item,
	output logic in_rdy,
	output logic out_vld,
	output res_t out_res,
	input logic out_rdy
);
	localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam logic [13:0] FLR = 14'(MTU_FLOOR);
	localparam logic [13:0] CEL = 14'(MTU_CEIL);

	// input register
	logic vld_s1;
	item_t item_s1;
	// result slots
	logic [1:0] rv_q;
	res_t [1:0] r_q;

	logic [13:0] live_q [2], best_q [2], next_q [2];
	logic [1:0] srch_q, valid_q;
	logic [7:0] fail_q [2];
	logic [1:0] ph_q [2];
	logic both_q;
	logic [PENDING_DEPTH-1:0] pv_q;
	logic [31:0] ptag_q [PENDING_DEPTH];
	logic [13:0] psz_q [PENDING_DEPTH];
	logic [PENDING_DEPTH-1:0] ppath_q;
	logic [31:0] ctr_q;

	logic busy, take;
	assign busy = |rv_q;
	assign take = vld_s1 && !busy;
	assign in_rdy = !vld_s1 || take;

	// next-state
	logic [13:0] live_n [2], best_n [2], next_n [2];
	logic [1:0] srch_n, valid_n;
	logic [7:0] fail_n [2];
	logic [1:0] ph_n [2];
	logic both_n;
	logic [PENDING_DEPTH-1:0] pv_n;
	logic [31:0] ctr_n;
	res_t [1:0] rr;
	logic [1:0] rn;
	logic wr_en;
	logic [PW-1:0] wr_idx;
	logic [31:0] wr_tag;
	logic [13:0] wr_sz;
	logic wr_path;

	// free slot and hit search, lowest index first in each
	logic free_any, hit_any;
	logic [PW-1:0] free_idx, hit_idx;
	logic [PENDING_DEPTH-1:0] pv_f;
	always_comb begin
		free_any = 1'b0; free_idx = '0; hit_any = 1'b0; hit_idx = '0;
		for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
			if (pv_q[i] && ptag_q[i] == item_s1.tag && ppath_q[i] == item_s1.inbound) begin
				hit_any = 1'b1; hit_idx = PW'(i);
			end
		end
		// a matched response frees its slot before the next probe is placed
		pv_f = pv_q;
		if (item_s1.func == F_RESP && hit_any) pv_f[hit_idx] = 1'b0;
		for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
			if (!pv_f[i]) begin free_any = 1'b1; free_idx = PW'(i); end
		end
	end

	always_comb begin
		logic [14:0] nx;
		logic [13:0] sz, gap, pv_st;
		logic p, rsp_probe, st_probe, do_start1;
		logic [13:0] pr_sz;
		logic pr_path;
		logic chg;
		logic [13:0] chg_nv, chg_pr;
		logic chg_fp, chg_path;
		logic [7:0] fr;
		live_n = live_q; best_n = best_q; next_n = next_q;
		srch_n = srch_q; valid_n = valid_q; fail_n = fail_q; ph_n = ph_q;
		both_n = both_q; pv_n = pv_q; ctr_n = ctr_q;
		rr = '0; rn = '0;
		wr_en = 1'b0; wr_idx = free_idx; wr_tag = ctr_q; wr_sz = '0; wr_path = 1'b0;
		rsp_probe = 1'b0; pr_sz = '0; pr_path = 1'b0;
		chg = 1'b0; chg_nv = '0; chg_pr = '0; chg_fp = 1'b0; chg_path = 1'b0;
		do_start1 = 1'b0;
		st_probe = 1'b0;
		p = item_s1.inbound;
		sz = psz_q[hit_idx];
		nx = '0; gap = '0; pv_st = '0; fr = '0;
		case (item_s1.func)
			F_ENABLE: begin
				if (!both_q) begin
					both_n = 1'b1;
					nx = {1'b0, cfg.fl} + {1'b0, cfg.st};
					pv_st = (nx > {1'b0, cfg.ce}) ? cfg.ce : nx[13:0];
					for (int q = 0; q < 2; q++) begin
						live_n[q] = cfg.fl; best_n[q] = cfg.fl;
						ph_n[q] = PH_UNKNOWN; srch_n[q] = 1'b0; valid_n[q] = 1'b0;
					end
					srch_n[0] = 1'b1; fail_n[0] = '0; ph_n[0] = PH_SEARCH;
					next_n[0] = pv_st;
					rsp_probe = 1'b1; pr_sz = pv_st; pr_path = 1'b0;
				end
			end
			F_DISABLE: begin
				if (both_q) begin
					both_n = 1'b0; srch_n = '0; pv_n = '0;
				end
			end
			F_RESP: begin
				if (hit_any) begin
					pv_n[hit_idx] = 1'b0;
					if (item_s1.ok) begin
						if (sz > best_q[p]) begin
							best_n[p] = sz;
							if (!p && sz != live_q[0]) begin
								chg = 1'b1; chg_nv = sz; chg_pr = live_q[0]; chg_fp = 1'b1;
								live_n[0] = sz;
							end
						end
						fail_n[p] = '0;
						if (srch_q[p]) begin
							if (sz < cfg.ce) begin
								nx = {1'b0, sz} + {1'b0, cfg.st};
								pv_st = (nx > {1'b0, cfg.ce}) ? cfg.ce : nx[13:0];
								next_n[p] = pv_st;
								rsp_probe = 1'b1; pr_sz = pv_st; pr_path = p;
							end else begin
								valid_n[p] = 1'b1; srch_n[p] = 1'b0; ph_n[p] = PH_VALID;
								if (!p && both_q && !srch_q[1]) do_start1 = 1'b1;
							end
						end
					end else begin
						fr = (fail_q[p] == 8'hFF) ? fail_q[p] : fail_q[p] + 8'd1;
						fail_n[p] = fr;
						if (fr >= cfg.limit) begin
							ph_n[p] = PH_BLACK; srch_n[p] = 1'b0;
							if (!p && best_q[0] != live_q[0]) begin
								chg = 1'b1; chg_nv = best_q[0]; chg_pr = live_q[0];
								live_n[0] = best_q[0];
							end
						end else if (srch_q[p]) begin
							gap = (sz > best_q[p]) ? sz - best_q[p] : '0;
							if (gap <= cfg.st) begin
								ph_n[p] = PH_VALID; srch_n[p] = 1'b0; valid_n[p] = 1'b1;
								if (!p && best_q[0] != live_q[0]) begin
									chg = 1'b1; chg_nv = best_q[0]; chg_pr = live_q[0];
									live_n[0] = best_q[0];
								end
								if (!p && both_q && !srch_q[1]) do_start1 = 1'b1;
							end else begin
								pv_st = best_q[p] + (gap >> 1);
								next_n[p] = pv_st;
								rsp_probe = 1'b1; pr_sz = pv_st; pr_path = p;
							end
						end
					end
					if (do_start1) begin
						nx = {1'b0, cfg.fl} + {1'b0, cfg.st};
						pv_st = (nx > {1'b0, cfg.ce}) ? cfg.ce : nx[13:0];
						srch_n[1] = 1'b1; valid_n[1] = 1'b0; fail_n[1] = '0;
						ph_n[1] = PH_SEARCH; live_n[1] = cfg.fl; best_n[1] = cfg.fl;
						next_n[1] = pv_st;
						rsp_probe = 1'b1; pr_sz = pv_st; pr_path = 1'b1;
					end
				end
			end
			F_INPROBE: begin
				if (item_s1.probe_bytes <= {2'b0, cfg.ce} &&
						item_s1.probe_bytes > {2'b0, live_q[1]}) begin
					chg = 1'b1; chg_nv = item_s1.probe_bytes[13:0]; chg_pr = live_q[1];
					chg_fp = 1'b1; chg_path = 1'b1;
					live_n[1] = item_s1.probe_bytes[13:0];
				end
			end
			F_SAMPLE: begin
				if (valid_q[0] && !srch_q[0]) begin
					if (item_s1.loss_permyriad > 14'd500) begin
						if (live_q[0] > cfg.fl) begin
							nx = {1'b0, cfg.fl} + {1'b0, cfg.st};
							pv_st = ({1'b0, live_q[0]} > nx) ? live_q[0] - cfg.st : cfg.fl;
							chg = 1'b1; chg_nv = pv_st; chg_pr = live_q[0];
							live_n[0] = pv_st;
						end
					end else if (item_s1.loss_permyriad < 14'd100 &&
							item_s1.rtt_millis < 32'd100) begin
						if (live_q[0] < cfg.ce) begin
							nx = {1'b0, live_q[0]} + {1'b0, cfg.st};
							pv_st = (nx > {1'b0, cfg.ce}) ? cfg.ce : nx[13:0];
							next_n[0] = pv_st;
							rsp_probe = 1'b1; pr_sz = pv_st;
						end
					end
				end
			end
			default: ;
		endcase
		st_probe = rsp_probe && free_any && pr_sz >= FLR && pr_sz <= CEL;
		if (st_probe) begin
			wr_en = 1'b1; wr_sz = pr_sz; wr_path = pr_path;
			pv_n[free_idx] = 1'b1;
			ctr_n = (ctr_q == 32'hFFFF_FFFF) ? 32'd1 : ctr_q + 32'd1;
		end
		// results in order: change first, then probe or reply
		if (chg) begin
			rr[0].kind = K_CHANGE; rr[0].on_inbound = chg_path;
			rr[0].size_bytes = {2'b0, chg_nv}; rr[0].prior_mtu = chg_pr;
			rr[0].from_probe = chg_fp;
			rn[0] = 1'b1;
		end
		if (st_probe) begin
			rr[1].kind = K_PROBE; rr[1].on_inbound = pr_path;
			rr[1].probe_tag = ctr_q; rr[1].size_bytes = {2'b0, pr_sz};
			rn[1] = 1'b1;
		end else if (item_s1.func == F_INPROBE) begin
			rr[1].kind = K_REPLY; rr[1].on_inbound = 1'b1;
			rr[1].probe_tag = item_s1.tag; rr[1].size_bytes = item_s1.probe_bytes;
			rr[1].reply_ok = (item_s1.probe_bytes <= {2'b0, cfg.ce});
			rn[1] = 1'b1;
		end
		for (int k = 0; k < 2; k++) rr[k].path_phase = ph_n[rr[k].on_inbound];
		rr[1].final_res = 1'b1;
		rr[0].final_res = !rn[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			rv_q <= '0;
			for (int q = 0; q < 2; q++) begin
				live_q[q] <= DEF_FLOOR; best_q[q] <= DEF_FLOOR;
				next_q[q] <= DEF_FLOOR + DEF_STEP;
				fail_q[q] <= '0; ph_q[q] <= PH_UNKNOWN;
			end
			srch_q <= '0; valid_q <= '0; both_q <= 1'b0;
			pv_q <= '0; ctr_q <= 32'd1;
		end else begin
			if (in_rdy) vld_s1 <= in_vld;
			if (busy) begin
				if (out_rdy) begin
					if (rv_q[0]) rv_q[0] <= 1'b0;
					else rv_q[1] <= 1'b0;
				end
			end else if (take) begin
				rv_q <= rn;
				live_q <= live_n; best_q <= best_n; next_q <= next_n;
				srch_q <= srch_n; valid_q <= valid_n; fail_q <= fail_n; ph_q <= ph_n;
				both_q <= both_n; pv_q <= pv_n; ctr_q <= ctr_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy) item_s1 <= in_item;
		if (take) r_q <= rr;
		if (take && wr_en) begin
			ptag_q[wr_idx] <= wr_tag;
			psz_q[wr_idx] <= wr_sz;
			ppath_q[wr_idx] <= wr_path;
		end
	end

	assign out_vld = busy;
	assign out_res = rv_q[0] ? r_q[0] : r_q[1];
endmodule

// ===== sv/pmps_checker.sv =====
module pmps_checker import pmps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tlast,
	input logic [1:0] m_axis_tuser,
	input logic [71:0] m_axis_tdata,
	input logic pready
);
`include "path_mtu_probe_search_assert.svh"
	`PMPS_ASSERT(a_ready, pready, "pready low")
	`PMPS_ASSERT(a_kind, m_axis_tvalid |-> m_axis_tuser <= K_REPLY, "bad kind")
	`PMPS_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped")
	// an incoming-path change is always followed by its reply
	`PMPS_ASSERT(a_chg, m_axis_tvalid && m_axis_tuser == K_CHANGE |-> !m_axis_tdata[0] || !m_axis_tlast, "in change last")
endmodule

bind path_mtu_probe_search pmps_checker u_chk (.*);

// ===== tb/sv/tb_path_mtu_probe_search.sv =====
`timescale 1ns / 100ps

module tb_path_mtu_probe_search;
	import pmps_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int PER_PHASE = 277;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic [2:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	path_mtu_probe_search uut (.*);

	// register contents as written
	logic [13:0] floor_r, ceil_r, step_r;
	logic [7:0] limit_r;

	// path and probe-table state
	int live_mtu[2], best_mtu[2], next_mtu[2];
	bit srch[2], vld[2];
	int fails[2];
	logic [1:0] phase_q[2];
	bit both_on;
	bit pend_v[8];
	logic [31:0] pend_tag[8];
	int pend_size[8];
	bit pend_path[8];
	logic [31:0] tag_ctr;

	res_t res_buf[2];
	int res_n;
	res_t want_q[$];
	item_t item_q[$];
	item_t cur;

	int burst_left, gap_left;
	int errs, items_in, words_out, cfg_writes, idle_cycles, hold_cnt, stall_mode, mode_cnt;
	bit hold_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void enqueue_item(item_t it);
		item_q.insert(item_q.size(), it);
	endfunction

	function automatic int eff_floor();
		int f, c;
		f = (floor_r < MTU_FLOOR_DEF) ? MTU_FLOOR_DEF : int'(floor_r);
		c = (ceil_r > MTU_CEIL_DEF) ? MTU_CEIL_DEF : int'(ceil_r);
		return (f >= c) ? int'(DEF_FLOOR) : f;
	endfunction

	function automatic int eff_ceil();
		int f, c;
		f = (floor_r < MTU_FLOOR_DEF) ? MTU_FLOOR_DEF : int'(floor_r);
		c = (ceil_r > MTU_CEIL_DEF) ? MTU_CEIL_DEF : int'(ceil_r);
		return (f >= c) ? int'(DEF_CEIL) : c;
	endfunction

	function automatic int eff_step();
		return (step_r == 0) ? int'(DEF_STEP) : int'(step_r);
	endfunction

	function automatic void add_res(logic [1:0] k, bit p, logic [31:0] t, int sz, int pr,
			bit fp, bit rk);
		if (res_n >= 2)
			return;
		res_buf[res_n] = '0;
		res_buf[res_n].kind = k;
		res_buf[res_n].on_inbound = p;
		res_buf[res_n].probe_tag = t;
		res_buf[res_n].size_bytes = sz[15:0];
		res_buf[res_n].prior_mtu = pr[13:0];
		res_buf[res_n].from_probe = fp;
		res_buf[res_n].reply_ok = rk;
		res_n++;
	endfunction

	function automatic void set_mtu(bit p, int nv, bit fp);
		if (nv == live_mtu[p])
			return;
		add_res(K_CHANGE, p, '0, nv, live_mtu[p], fp, 1'b0);
		live_mtu[p] = nv;
	endfunction

	function automatic void launch_probe(int sz, bit p);
		if (sz < MTU_FLOOR_DEF || sz > MTU_CEIL_DEF)
			return;
		for (int i = 0; i < 8; i++) begin
			if (!pend_v[i]) begin
				pend_v[i] = 1'b1;
				pend_tag[i] = tag_ctr;
				pend_size[i] = sz & 16'h3fff;
				pend_path[i] = p;
				add_res(K_PROBE, p, tag_ctr, sz, 0, 1'b0, 1'b0);
				tag_ctr = tag_ctr + 1;
				if (tag_ctr == 0)
					tag_ctr = 1;
				return;
			end
		end
	endfunction

	function automatic void begin_search(bit p);
		int fl, nx;
		fl = eff_floor();
		nx = fl + eff_step();
		if (p && !both_on)
			return;
		srch[p] = 1'b1;
		vld[p] = 1'b0;
		fails[p] = 0;
		phase_q[p] = PH_SEARCH;
		live_mtu[p] = fl;
		best_mtu[p] = fl;
		next_mtu[p] = (nx > eff_ceil()) ? eff_ceil() : nx;
		launch_probe(next_mtu[p], p);
	endfunction

	function automatic void take_response(logic [31:0] t, bit good, bit p);
		int hit, sz, ce, st, gap, nx;
		hit = -1;
		ce = eff_ceil();
		st = eff_step();
		for (int i = 0; i < 8; i++)
			if (hit < 0 && pend_v[i] && pend_tag[i] == t && pend_path[i] == p)
				hit = i;
		if (hit < 0)
			return;
		sz = pend_size[hit];
		pend_v[hit] = 1'b0;
		if (good) begin
			if (sz > best_mtu[p]) begin
				best_mtu[p] = sz;
				if (!p)
					set_mtu(1'b0, sz, 1'b1);
			end
			fails[p] = 0;
			if (srch[p]) begin
				if (sz < ce) begin
					nx = sz + st;
					next_mtu[p] = (nx > ce) ? ce : nx;
					launch_probe(next_mtu[p], p);
				end else begin
					vld[p] = 1'b1;
					srch[p] = 1'b0;
					phase_q[p] = PH_VALID;
					if (!p && both_on && !srch[1])
						begin_search(1'b1);
				end
			end
			return;
		end
		if (fails[p] < 255)
			fails[p]++;
		if (fails[p] >= limit_r) begin
			phase_q[p] = PH_BLACK;
			srch[p] = 1'b0;
			if (!p)
				set_mtu(1'b0, best_mtu[0], 1'b0);
		end else if (srch[p]) begin
			gap = (sz > best_mtu[p]) ? sz - best_mtu[p] : 0;
			if (gap <= st) begin
				phase_q[p] = PH_VALID;
				srch[p] = 1'b0;
				vld[p] = 1'b1;
				if (!p)
					set_mtu(1'b0, best_mtu[0], 1'b0);
				if (!p && both_on && !srch[1])
					begin_search(1'b1);
			end else begin
				next_mtu[p] = best_mtu[p] + gap / 2;
				launch_probe(next_mtu[p], p);
			end
		end
	endfunction

	// work out the words an accepted item must produce
	function automatic void track_item(item_t it);
		int fl, ce, st, nx;
		bit good;
		res_n = 0;
		fl = eff_floor();
		ce = eff_ceil();
		st = eff_step();
		case (it.func)
			F_ENABLE: begin
				if (!both_on) begin
					both_on = 1'b1;
					for (int p = 0; p < 2; p++) begin
						live_mtu[p] = fl;
						best_mtu[p] = fl;
						phase_q[p] = PH_UNKNOWN;
						srch[p] = 1'b0;
						vld[p] = 1'b0;
					end
					begin_search(1'b0);
				end
			end
			F_DISABLE: begin
				if (both_on) begin
					both_on = 1'b0;
					srch[0] = 1'b0;
					srch[1] = 1'b0;
					for (int i = 0; i < 8; i++)
						pend_v[i] = 1'b0;
				end
			end
			F_RESP: take_response(it.tag, it.ok, it.inbound);
			F_INPROBE: begin
				good = (it.probe_bytes <= ce);
				if (good && it.probe_bytes > live_mtu[1])
					set_mtu(1'b1, it.probe_bytes, 1'b1);
				add_res(K_REPLY, 1'b1, it.tag, it.probe_bytes, 0, 1'b0, good);
			end
			F_SAMPLE: begin
				if (vld[0] && !srch[0]) begin
					if (it.loss_permyriad > 500) begin
						if (live_mtu[0] > fl)
							set_mtu(1'b0, (live_mtu[0] > fl + st) ? live_mtu[0] - st : fl,
								1'b0);
					end else if (it.loss_permyriad < 100 && it.rtt_millis < 100) begin
						if (live_mtu[0] < ce) begin
							nx = live_mtu[0] + st;
							next_mtu[0] = (nx > ce) ? ce : nx;
							launch_probe(next_mtu[0], 1'b0);
						end
					end
				end
			end
			default: ;
		endcase
		for (int k = 0; k < res_n; k++) begin
			res_buf[k].path_phase = phase_q[res_buf[k].on_inbound];
			res_buf[k].final_res = (k == res_n - 1);
			want_q.insert(want_q.size(), res_buf[k]);
		end
	endfunction

	// sender: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				track_item(cur);
				items_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (item_q.size() > 0) begin
					cur = item_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= cur.func;
					s_axis_tdata <= {cur.rtt_millis, cur.loss_permyriad, cur.probe_bytes,
						cur.inbound, cur.ok, cur.tag};
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else
						burst_left <= burst_left - 1;
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern plus one long hold when asked
	always @(posedge clk or negedge arst_n) begin
		res_t got, exp_w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_cnt <= 0;
			mode_cnt <= 0;
			stall_mode <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				words_out++;
				got.kind = m_axis_tuser;
				got.on_inbound = m_axis_tdata[0];
				got.probe_tag = m_axis_tdata[32:1];
				got.size_bytes = m_axis_tdata[48:33];
				got.prior_mtu = m_axis_tdata[62:49];
				got.from_probe = m_axis_tdata[63];
				got.reply_ok = m_axis_tdata[64];
				got.path_phase = m_axis_tdata[66:65];
				got.final_res = m_axis_tlast;
				if (want_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected word: %p", got);
				end else begin
					exp_w = want_q.pop_front();
					if (got !== exp_w) begin
						errs++;
						if (errs <= 10)
							$display("mismatch: expected %p, got %p", exp_w, got);
					end
				end
			end
			if (hold_req && hold_cnt == 0)
				hold_cnt <= HOLD_CYCLES;
			if (hold_cnt > 0) begin
				if (hold_cnt == 1)
					hold_req <= 1'b0;
				hold_cnt <= hold_cnt - 1;
				m_axis_tready <= 1'b0;
			end else begin
				if (mode_cnt == 0) begin
					stall_mode <= $urandom_range(0, 2);
					mode_cnt <= 64;
				end else
					mode_cnt <= mode_cnt - 1;
				case (stall_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 1);
					default: m_axis_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("tb_path_mtu_probe_search failed");
			$finish;
		end
	end

	function automatic item_t mk(logic [2:0] f, logic [31:0] t, bit good, bit inb,
			logic [15:0] pb, logic [13:0] loss, logic [31:0] rtt);
		item_t it;
		it.func = f;
		it.tag = t;
		it.ok = good;
		it.inbound = inb;
		it.probe_bytes = pb;
		it.loss_permyriad = loss;
		it.rtt_millis = rtt;
		return it;
	endfunction

	// a pending tag, mostly one that is live
	function automatic item_t rand_resp(int good_pct);
		int start;
		bit p;
		logic [31:0] t;
		t = $urandom;
		p = $urandom_range(0, 1);
		start = $urandom_range(0, 7);
		if ($urandom_range(0, 99) < 88)
			for (int i = 0; i < 8; i++)
				if (pend_v[(start + i) % 8]) begin
					t = pend_tag[(start + i) % 8];
					p = pend_path[(start + i) % 8];
					break;
				end
		if ($urandom_range(0, 19) == 0)
			p = ~p;
		return mk(F_RESP, t, $urandom_range(0, 99) < good_pct, p, $urandom, $urandom,
			$urandom);
	endfunction

	function automatic item_t rand_item(int good_pct);
		int r;
		logic [13:0] loss;
		logic [31:0] rtt;
		r = $urandom_range(0, 99);
		if (!both_on && $urandom_range(0, 2) == 0)
			return mk(F_ENABLE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (r < 55)
			return rand_resp(good_pct);
		if (r < 68) begin
			loss = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 700);
			rtt = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 120);
			return mk(F_SAMPLE, $urandom, $urandom, $urandom, $urandom, loss, rtt);
		end
		if (r < 80)
			return mk(F_INPROBE, $urandom, $urandom, $urandom,
				($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(500, 9100),
				$urandom, $urandom);
		if (r < 86)
			return mk(F_ENABLE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (r < 90)
			return mk(F_DISABLE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (r < 94)
			return mk($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
		return mk(F_RESP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	task automatic wait_drained();
		while (item_q.size() > 0 || s_axis_tvalid || want_q.size() > 0)
			@(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_FLOOR: floor_r = val[13:0];
			REG_CEIL: ceil_r = val[13:0];
			REG_STEP: step_r = val[13:0];
			default: limit_r = val[7:0];
		endcase
		cfg_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_regs(int fl, int ce, int st, int lim);
		logic [31:0] hi;
		hi = $urandom;
		reg_write(REG_FLOOR, {hi[31:14], fl[13:0]});
		reg_write(REG_CEIL, {hi[17:0], ce[13:0]});
		reg_write(REG_STEP, {~hi[31:14], st[13:0]});
		reg_write(REG_LIMIT, {~hi[23:0], lim[7:0]});
	endtask

	task automatic run_random(int n, int good_pct);
		int left;
		left = n;
		while (left > 0) begin
			for (int k = 0; k < $urandom_range(1, 6) && left > 0; k++, left--)
				enqueue_item(rand_item(good_pct));
			wait_drained();
		end
	endtask

	task automatic directed();
		enqueue_item(mk(F_SAMPLE, '0, 0, 0, '0, '0, '0));
		enqueue_item(mk(F_DISABLE, '1, 1, 1, '1, '1, '1));
		enqueue_item(mk(F_ENABLE, '0, 0, 0, '0, '0, '0));
		enqueue_item(mk(F_ENABLE, '1, 1, 1, '1, '1, '1));
		wait_drained();
		enqueue_item(rand_resp(100));
		enqueue_item(mk(F_RESP, 32'h0bad_f00d, 1, 0, '0, '0, '0));
		wait_drained();
		enqueue_item(rand_resp(0));
		wait_drained();
		enqueue_item(rand_resp(0));
		wait_drained();
		enqueue_item(rand_resp(100));
		enqueue_item(mk(F_INPROBE, '0, 0, 0, 16'd0, '0, '0));
		enqueue_item(mk(F_INPROBE, '1, 1, 1, 16'hffff, '1, '1));
		enqueue_item(mk(F_INPROBE, 32'h5555_aaaa, 0, 1, 16'd1500, '0, '0));
		enqueue_item(mk(3'd5, '1, 1, 1, '1, '1, '1));
		enqueue_item(mk(3'd6, '0, 0, 0, '0, '0, '0));
		enqueue_item(mk(3'd7, '1, 1, 1, '1, '1, '1));
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			enqueue_item(rand_resp(100));
			wait_drained();
		end
		enqueue_item(mk(F_SAMPLE, '0, 0, 0, '0, 14'd10000, 32'hffff_ffff));
		enqueue_item(mk(F_SAMPLE, '0, 0, 0, '0, 14'd0, 32'd0));
		enqueue_item(mk(F_DISABLE, '0, 0, 0, '0, '0, '0));
		enqueue_item(mk(F_DISABLE, '0, 0, 0, '0, '0, '0));
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		floor_r = DEF_FLOOR;
		ceil_r = DEF_CEIL;
		step_r = DEF_STEP;
		limit_r = DEF_LIMIT;
		for (int p = 0; p < 2; p++) begin
			live_mtu[p] = DEF_FLOOR;
			best_mtu[p] = DEF_FLOOR;
			next_mtu[p] = DEF_FLOOR + DEF_STEP;
			srch[p] = 1'b0;
			vld[p] = 1'b0;
			fails[p] = 0;
			phase_q[p] = PH_UNKNOWN;
		end
		for (int i = 0; i < 8; i++)
			pend_v[i] = 1'b0;
		both_on = 1'b0;
		tag_ctr = 1;
		errs = 0;
		items_in = 0;
		words_out = 0;
		cfg_writes = 0;
		idle_cycles = 0;
		hold_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();
		run_random(PER_PHASE, 70);

		// widest range, finest step, blackhole almost never
		set_regs(576, 9000, 1, 255);
		run_random(PER_PHASE, 75);
		wait_drained();
		repeat (10) @(posedge clk);

		// floor below minimum, ceiling above maximum, zero step, zero limit
		set_regs(0, 16383, 0, 0);
		run_random(PER_PHASE / 2, 60);
		// long receiver hold while the sender keeps offering replies
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			enqueue_item(mk(F_INPROBE, $urandom, $urandom, $urandom, $urandom_range(500,
				9100), $urandom, $urandom));
		wait_drained();
		repeat (10) @(posedge clk);

		// narrowest range, largest step
		set_regs(8999, 9000, 8424, 1);
		run_random(PER_PHASE / 2, 60);
		wait_drained();
		repeat (10) @(posedge clk);

		// floor above ceiling falls back to defaults
		set_regs(3000, 1000, 500, 5);
		run_random(PER_PHASE, 55);
		wait_drained();
		repeat (10) @(posedge clk);

		set_regs(1000, 4000, 300, 2);
		run_random(PER_PHASE, 65);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("run covered %0d items, %0d result words, %0d register writes,", items_in,
			words_out, cfg_writes);
		$display("six register settings and one long output hold; %0d mismatches", errs);
		if (errs == 0 && want_q.size() == 0)
			$display("tb_path_mtu_probe_search passed");
		else
			$display("tb_path_mtu_probe_search failed");
		$finish;
	end

endmodule
